FILE: hdl/htlp_pkg.sv
`default_nettype none

package htlp_pkg;

    localparam int TABLE_SIZE = 11;
    localparam int ADDR_BITS  = 20;

    localparam int SLOT_BITS  = $clog2(TABLE_SIZE);
    localparam int CNT_BITS   = $clog2(TABLE_SIZE + 1);
    localparam int LABEL_BITS = 64;
    localparam int FADDR_BITS = 20;
    localparam int SIDX_BITS  = 4;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_SEARCH = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_FULL    = 2'd1,
        ST_FOUND   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd                    cmd;
        logic [LABEL_BITS-1:0]   label;
        logic [FADDR_BITS-1:0]   address;
    } t_in;

    typedef struct packed {
        t_status                 status;
        logic [FADDR_BITS-1:0]   found_address;
        logic [SIDX_BITS-1:0]    slot_index;
    } t_out;

    // one stored symbol
    typedef struct packed {
        logic [LABEL_BITS-1:0]   label;
        logic [ADDR_BITS-1:0]    address;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    typedef logic [SLOT_BITS-1:0] t_home_tbl [256];

    // home slot for every value of the first label character
    function automatic t_home_tbl build_home();
        t_home_tbl tbl;
        for (int i = 0; i < 256; i++) begin
            tbl[i] = SLOT_BITS'(i % TABLE_SIZE);
        end
        return tbl;
    endfunction

    localparam t_home_tbl HOME_TBL = build_home();

endpackage

`default_nettype wire

FILE: hdl/htlp_ram.sv
`default_nettype none

module htlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/hash_table_linear_probe.sv
`default_nettype none

// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_ready   i_in  (cmd, label, address)
// out       output     o_out_valid / i_out_ready o_out (status, found_address, slot_index)
//
// insert: probes from home to a free slot or a full table, then the result register
// search: one slot compared per cycle behind the registered read of the symbol ram,
//   at most TABLE_SIZE slots, then the result register
// one transaction in flight; a new one is taken once the result has been taken
// synchronous active-low reset empties the table by clearing the slot valid bits
// a stalled result simply holds in the output register

module hash_table_linear_probe (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire htlp_pkg::t_in i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output htlp_pkg::t_out     o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_SRCH,
        S_OUT
    } t_state;

    t_state                                r_state;
    logic [htlp_pkg::TABLE_SIZE-1:0]       r_valid;
    logic [htlp_pkg::LABEL_BITS-1:0]       r_label;
    logic [htlp_pkg::ADDR_BITS-1:0]        r_addr;
    logic [htlp_pkg::SLOT_BITS-1:0]        r_pos;
    logic [htlp_pkg::CNT_BITS-1:0]         r_cnt;
    // compare stage of the search pipeline
    logic                                  r_pd_live;
    logic                                  r_pd_vld;
    logic                                  r_pd_last;
    logic [htlp_pkg::SLOT_BITS-1:0]        r_pd_pos;
    htlp_pkg::t_out                        r_out;

    logic [htlp_pkg::SLOT_BITS-1:0]        n_pos;
    logic                                  w_last;
    logic                                  w_we;
    htlp_pkg::t_entry                      w_wdata;
    htlp_pkg::t_entry                      w_rdata;
    logic [htlp_pkg::ENTRY_BITS-1:0]       w_rdata_raw;
    logic                                  w_match;
    logic [htlp_pkg::ADDR_BITS+htlp_pkg::FADDR_BITS-1:0] w_faddr_ext;
    logic [htlp_pkg::SLOT_BITS+htlp_pkg::SIDX_BITS-1:0]  w_pos_ext;
    logic [htlp_pkg::SLOT_BITS+htlp_pkg::SIDX_BITS-1:0]  w_pd_pos_ext;
    logic [htlp_pkg::ADDR_BITS+htlp_pkg::FADDR_BITS-1:0] w_in_addr_ext;

    assign n_pos  = (r_pos == htlp_pkg::SLOT_BITS'(htlp_pkg::TABLE_SIZE - 1))
                  ? '0 : r_pos + 1'b1;
    assign w_last = (r_cnt == htlp_pkg::CNT_BITS'(htlp_pkg::TABLE_SIZE - 1));

    assign w_we          = (r_state == S_INS) && !r_valid[r_pos];
    assign w_wdata.label   = r_label;
    assign w_wdata.address = r_addr;
    assign w_rdata       = htlp_pkg::t_entry'(w_rdata_raw);
    assign w_match       = r_pd_live && r_pd_vld && (w_rdata.label == r_label);

    // output fields are masked or zero extended to their port widths
    assign w_faddr_ext   = {{htlp_pkg::FADDR_BITS{1'b0}}, w_rdata.address};
    assign w_pos_ext     = {{htlp_pkg::SIDX_BITS{1'b0}}, r_pos};
    assign w_pd_pos_ext  = {{htlp_pkg::SIDX_BITS{1'b0}}, r_pd_pos};
    assign w_in_addr_ext = {{htlp_pkg::ADDR_BITS{1'b0}}, i_in.address};

    htlp_ram #(
        .WIDTH (htlp_pkg::ENTRY_BITS),
        .DEPTH (htlp_pkg::TABLE_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_pos),
        .i_wdata (w_wdata),
        .i_raddr (r_pos),
        .o_rdata (w_rdata_raw)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_pd_live <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_label   <= i_in.label;
                        r_addr    <= w_in_addr_ext[htlp_pkg::ADDR_BITS-1:0];
                        r_pos     <= htlp_pkg::HOME_TBL[i_in.label[7:0]];
                        r_cnt     <= '0;
                        r_pd_live <= 1'b0;
                        r_state   <= (i_in.cmd == htlp_pkg::CMD_INSERT) ? S_INS : S_SRCH;
                    end
                end
                S_INS: begin
                    if (!r_valid[r_pos]) begin
                        r_valid[r_pos]      <= 1'b1;
                        r_out.status        <= htlp_pkg::ST_ADDED;
                        r_out.found_address <= '0;
                        r_out.slot_index    <= w_pos_ext[htlp_pkg::SIDX_BITS-1:0];
                        r_state             <= S_OUT;
                    end else if (w_last) begin
                        r_out.status        <= htlp_pkg::ST_FULL;
                        r_out.found_address <= '0;
                        r_out.slot_index    <= '0;
                        r_state             <= S_OUT;
                    end else begin
                        r_pos <= n_pos;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SRCH: begin
                    // issue side: read the next slot while the previous one is compared
                    r_pd_pos  <= r_pos;
                    r_pd_vld  <= r_valid[r_pos];
                    r_pd_last <= w_last;
                    r_pd_live <= 1'b1;
                    r_pos     <= n_pos;
                    r_cnt     <= r_cnt + 1'b1;
                    if (w_match) begin
                        r_out.status        <= htlp_pkg::ST_FOUND;
                        r_out.found_address <= w_faddr_ext[htlp_pkg::FADDR_BITS-1:0];
                        r_out.slot_index    <= w_pd_pos_ext[htlp_pkg::SIDX_BITS-1:0];
                        r_state             <= S_OUT;
                    end else if (r_pd_live && r_pd_last) begin
                        r_out.status        <= htlp_pkg::ST_MISSING;
                        r_out.found_address <= '0;
                        r_out.slot_index    <= '0;
                        r_state             <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             req_valid   = 1'b0;
    htlp_pkg::t_in    req_data    = '0;
    logic             rsp_ready   = 1'b0;
    logic             req_ready;
    logic             rsp_valid;
    htlp_pkg::t_out   rsp_data;

    // shadow copy of the symbol table
    logic                            tbl_used  [htlp_pkg::TABLE_SIZE];
    logic [htlp_pkg::LABEL_BITS-1:0] tbl_label [htlp_pkg::TABLE_SIZE];
    logic [htlp_pkg::ADDR_BITS-1:0]  tbl_addr  [htlp_pkg::TABLE_SIZE];

    htlp_pkg::t_in  pending_q [$];
    htlp_pkg::t_out lookup_q  [$];

    // labels that the generator knows will be in the table
    logic [htlp_pkg::LABEL_BITS-1:0] stored_labels [$];
    int                              inserts_queued = 0;

    int unsigned send_idle_pct = 0;
    int unsigned rsp_stall_pct = 0;

    int n_errors  = 0;
    int n_checked = 0;
    int n_added   = 0;
    int n_full    = 0;
    int n_hit     = 0;
    int n_miss    = 0;

    hash_table_linear_probe u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_in        (req_data),
        .o_out_valid (rsp_valid),
        .i_out_ready (rsp_ready),
        .o_out       (rsp_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        for (int s = 0; s < htlp_pkg::TABLE_SIZE; s++) begin
            tbl_used[s]  = 1'b0;
            tbl_label[s] = '0;
            tbl_addr[s]  = '0;
        end
    end

    // probe the shadow table the way the block does, updating it on insert
    function automatic htlp_pkg::t_out probe_table(input htlp_pkg::t_in req);
        htlp_pkg::t_out res;
        int unsigned    pos;
        bit             done;
        res.status        = (req.cmd == htlp_pkg::CMD_INSERT) ? htlp_pkg::ST_FULL
                                                              : htlp_pkg::ST_MISSING;
        res.found_address = '0;
        res.slot_index    = '0;
        pos  = req.label[7:0] % htlp_pkg::TABLE_SIZE;
        done = 1'b0;
        for (int n = 0; n < htlp_pkg::TABLE_SIZE && !done; n++) begin
            if (req.cmd == htlp_pkg::CMD_INSERT) begin
                if (!tbl_used[pos]) begin
                    tbl_used[pos]  = 1'b1;
                    tbl_label[pos] = req.label;
                    tbl_addr[pos]  = req.address[htlp_pkg::ADDR_BITS-1:0];
                    res.status     = htlp_pkg::ST_ADDED;
                    res.slot_index = htlp_pkg::SIDX_BITS'(pos);
                    done           = 1'b1;
                end
            end else if (tbl_used[pos] && tbl_label[pos] == req.label) begin
                res.status        = htlp_pkg::ST_FOUND;
                res.found_address = htlp_pkg::FADDR_BITS'(tbl_addr[pos]);
                res.slot_index    = htlp_pkg::SIDX_BITS'(pos);
                done              = 1'b1;
            end
            if (!done) begin
                pos = (pos + 1 == htlp_pkg::TABLE_SIZE) ? 0 : pos + 1;
            end
        end
        return res;
    endfunction

    // short zero-padded printable label, first character in the low byte
    function automatic logic [htlp_pkg::LABEL_BITS-1:0] rand_ascii_label();
        logic [htlp_pkg::LABEL_BITS-1:0] lbl;
        int unsigned                     len;
        lbl = '0;
        len = $urandom_range(8, 1);
        for (int c = 0; c < len; c++) begin
            lbl[c*8 +: 8] = 8'($urandom_range(8'h7e, 8'h21));
        end
        return lbl;
    endfunction

    task automatic add_item(input htlp_pkg::t_cmd cmd,
                            input logic [htlp_pkg::LABEL_BITS-1:0] lbl,
                            input logic [htlp_pkg::FADDR_BITS-1:0] addr);
        htlp_pkg::t_in req;
        req.cmd     = cmd;
        req.label   = lbl;
        req.address = addr;
        pending_q.push_back(req);
        if (cmd == htlp_pkg::CMD_INSERT) begin
            if (inserts_queued < htlp_pkg::TABLE_SIZE) begin
                stored_labels.push_back(lbl);
            end
            inserts_queued++;
        end
    endtask

    task automatic add_random_items(input int count);
        int unsigned                     pick;
        logic [htlp_pkg::LABEL_BITS-1:0] lbl;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (stored_labels.size() != 0) begin
                lbl = stored_labels[$urandom_range(stored_labels.size() - 1)];
            end else begin
                lbl = rand_ascii_label();
            end
            if (pick < 40) begin
                add_item(htlp_pkg::CMD_SEARCH, lbl, htlp_pkg::FADDR_BITS'($urandom));
            end else if (pick < 60) begin
                // near miss: one bit away from a stored label
                lbl ^= (64'd1 << $urandom_range(htlp_pkg::LABEL_BITS - 1));
                add_item(htlp_pkg::CMD_SEARCH, lbl, htlp_pkg::FADDR_BITS'($urandom));
            end else if (pick < 70) begin
                add_item(htlp_pkg::CMD_SEARCH, rand_ascii_label(),
                         htlp_pkg::FADDR_BITS'($urandom));
            end else if (pick < 85) begin
                if ($urandom_range(1) == 0) begin
                    lbl = {$urandom, $urandom};
                end
                add_item(htlp_pkg::CMD_INSERT, lbl, htlp_pkg::FADDR_BITS'($urandom));
            end else begin
                add_item(htlp_pkg::CMD_SEARCH, {$urandom, $urandom},
                         htlp_pkg::FADDR_BITS'($urandom));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || req_valid || lookup_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else if (!req_valid || req_ready) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req_valid <= 1'b1;
                req_data  <= pending_q.pop_front();
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // monitor: check responses in order, predict each accepted request
    always @(posedge i_clk) begin
        htlp_pkg::t_out want;
        if (i_rst_n) begin
            if (rsp_valid && rsp_ready) begin
                if (lookup_q.size() == 0) begin
                    $error("response with nothing outstanding: status %0d addr %0h slot %0d",
                           rsp_data.status, rsp_data.found_address, rsp_data.slot_index);
                    n_errors++;
                end else begin
                    want = lookup_q.pop_front();
                    n_checked++;
                    case (want.status)
                        htlp_pkg::ST_ADDED:   n_added++;
                        htlp_pkg::ST_FULL:    n_full++;
                        htlp_pkg::ST_FOUND:   n_hit++;
                        htlp_pkg::ST_MISSING: n_miss++;
                        default:              ;
                    endcase
                    if (rsp_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                        n_errors++;
                    end
                    if (rsp_data.found_address !== want.found_address) begin
                        $error("found_address: expected %0h, got %0h",
                               want.found_address, rsp_data.found_address);
                        n_errors++;
                    end
                    if (rsp_data.slot_index !== want.slot_index) begin
                        $error("slot_index: expected %0d, got %0d",
                               want.slot_index, rsp_data.slot_index);
                        n_errors++;
                    end
                end
            end
            if (req_valid && req_ready) begin
                lookup_q.push_back(probe_table(req_data));
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // phase 0: no idling, directed sequence first
        add_item(htlp_pkg::CMD_SEARCH, 64'h0, 20'h0);              // empty table
        add_item(htlp_pkg::CMD_INSERT, 64'h0, 20'h00000);          // zero label, home 0
        add_item(htlp_pkg::CMD_INSERT, 64'h0, 20'hfffff);          // duplicate takes next slot
        add_item(htlp_pkg::CMD_SEARCH, 64'h0, 20'hfffff);          // first duplicate wins
        add_item(htlp_pkg::CMD_INSERT, 64'h41, 20'h12345);         // home is last slot
        add_item(htlp_pkg::CMD_INSERT, 64'h4241, 20'h54321);       // wraps to slot 0 and on
        add_item(htlp_pkg::CMD_INSERT, {htlp_pkg::LABEL_BITS{1'b1}}, 20'hfffff);
        add_item(htlp_pkg::CMD_SEARCH, {htlp_pkg::LABEL_BITS{1'b1}}, 20'h0);
        add_item(htlp_pkg::CMD_SEARCH, 64'h4241, 20'h0);           // search across the wrap
        add_item(htlp_pkg::CMD_SEARCH, 64'h4341, 20'h0);           // same home, absent
        add_item(htlp_pkg::CMD_SEARCH, 64'h8000_0000_0000_0000, 20'h0);
        add_item(htlp_pkg::CMD_SEARCH, 64'h0100, 20'h0);
        for (int i = 0; i < htlp_pkg::TABLE_SIZE - 5; i++) begin
            add_item(htlp_pkg::CMD_INSERT, rand_ascii_label(),
                     htlp_pkg::FADDR_BITS'($urandom));
        end
        add_item(htlp_pkg::CMD_INSERT, 64'h41, 20'h0);             // table full
        add_item(htlp_pkg::CMD_SEARCH, 64'h41, 20'h0);
        add_item(htlp_pkg::CMD_SEARCH, stored_labels[stored_labels.size() - 1], 20'h0);
        add_random_items(183);
        wait_drained();

        send_idle_pct = 52;
        rsp_stall_pct = 0;
        add_random_items(183);
        wait_drained();

        send_idle_pct = 0;
        rsp_stall_pct = 52;
        add_random_items(183);
        wait_drained();

        send_idle_pct = 28;
        rsp_stall_pct = 28;
        add_random_items(183);
        wait_drained();

        repeat (30) @(negedge i_clk);
        if (lookup_q.size() != 0) begin
            $error("%0d responses never arrived", lookup_q.size());
            n_errors++;
        end
        $display("checked %0d responses over four idle/stall mixes", n_checked);
        $display("inserted %0d, table full %0d, search hits %0d, search misses %0d",
                 n_added, n_full, n_hit, n_miss);
        if (n_errors == 0) begin
            $display("[hash_table_linear_probe] OK");
        end else begin
            $display("[hash_table_linear_probe] ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[hash_table_linear_probe] ERROR");
        $finish;
    end

endmodule
